// ----- rtl/aes256cbc_pkg.sv -----
package aes256cbc_pkg;

  localparam int WORD_W      = 64;
  localparam int BLOCK_W     = 128;
  localparam int NUM_ROUNDS  = 14;
  localparam int NUM_RK      = NUM_ROUNDS + 1;
  localparam int RK_AW       = $clog2(NUM_RK);
  localparam int EXP_WORDS   = 4 * NUM_RK;
  localparam int EXP_CW      = $clog2(EXP_WORDS);
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [7:0]         gf_byte_t;
  typedef logic [31:0]        kword_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_MODE = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_KEY0,
    CS_ROUND
  } core_state_t;

  typedef struct packed {
    block_t data;
    logic   first_block;
  } q_entry_t;

  typedef struct packed {
    logic busy;
    logic decrypt;
  } key_status_t;

  typedef struct packed {
    logic             we;
    logic [RK_AW-1:0] addr;
    block_t           data;
  } rk_write_t;

  typedef logic [7:0] sbox_t [256];
  typedef logic [7:0] coef4_t [4];

  localparam sbox_t SBOX = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic sbox_t build_inv_sbox();
    sbox_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam sbox_t INV_SBOX = build_inv_sbox();

  localparam coef4_t FWD_COEF = '{8'd2, 8'd3, 8'd1, 8'd1};
  localparam coef4_t INV_COEF = '{8'd14, 8'd11, 8'd13, 8'd9};

  function automatic gf_byte_t xtime(input gf_byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // multiply by a small constant (below 16)
  function automatic gf_byte_t mulc(input gf_byte_t a, input gf_byte_t c);
    gf_byte_t x2, x4, x8, r;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    r  = 8'h00;
    if (c[0]) r = r ^ a;
    if (c[1]) r = r ^ x2;
    if (c[2]) r = r ^ x4;
    if (c[3]) r = r ^ x8;
    return r;
  endfunction

  function automatic block_t sub_block(input block_t s, input logic inv);
    block_t r;
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
    end
    return r;
  endfunction

  function automatic block_t shift_block(input block_t s, input logic inv);
    block_t r;
    for (int rw = 0; rw < 4; rw++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          r[127-8*(rw+4*((c+rw)%4)) -: 8] = s[127-8*(rw+4*c) -: 8];
        end else begin
          r[127-8*(rw+4*c) -: 8] = s[127-8*(rw+4*((c+rw)%4)) -: 8];
        end
      end
    end
    return r;
  endfunction

  function automatic block_t mix_block(input block_t s, input logic inv);
    block_t   r;
    gf_byte_t o;
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        o = 8'h00;
        for (int k = 0; k < 4; k++) begin
          o = o ^ mulc(s[127-8*(4*c+k) -: 8],
                       inv ? INV_COEF[(k+4-rw)%4] : FWD_COEF[(k+4-rw)%4]);
        end
        r[127-8*(4*c+rw) -: 8] = o;
      end
    end
    return r;
  endfunction

  function automatic kword_t sub_word(input kword_t w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// ----- rtl/aes256cbc_ifs.sv -----
interface aes256cbc_in_if;
  logic                              valid;
  logic                              ready;
  logic [aes256cbc_pkg::WORD_W-1:0]  data_high;
  logic [aes256cbc_pkg::WORD_W-1:0]  data_low;
  logic                              first_block;
  modport source (output valid, data_high, data_low, first_block, input ready);
  modport sink (input valid, data_high, data_low, first_block, output ready);
endinterface

interface aes256cbc_out_if;
  logic                              valid;
  logic                              ready;
  logic [aes256cbc_pkg::WORD_W-1:0]  result_high;
  logic [aes256cbc_pkg::WORD_W-1:0]  result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

interface aes256cbc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [aes256cbc_pkg::CFG_IDX_W-1:0]  index;
  logic [aes256cbc_pkg::WORD_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/aes256_cbc_cipher_top.sv -----
// Path: queue pop, initial key add, then 14 rounds in the round unit; the result
//   register then holds until taken, and the last round waits while it is still full.
// Blocks pass one at a time through the single shared round unit; others wait in the queue.
// Reset: synchronous active-low; clears chaining value, key and mode to zero, then
//   runs a key expansion during which blocks queue but do not start.
// Each key register write reruns the expansion.
module aes256_cbc_cipher_top #(
  parameter int QDepth = aes256cbc_pkg::QUEUE_DEPTH
) (
  input logic              clk,
  input logic              rst_n,
  aes256cbc_in_if.sink     in_ch,
  aes256cbc_out_if.source  out_ch,
  aes256cbc_cfg_if.sink    cfg_ch
);
  import aes256cbc_pkg::*;

  logic             q_valid;
  q_entry_t         q_head;
  logic             q_pop;
  key_status_t      status;
  rk_write_t        rk_wr;
  logic [RK_AW-1:0] rk_raddr;
  block_t           rk;

  aes256cbc_front #(.QDepth(QDepth)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  aes256cbc_keyexp u_keyexp (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .status(status),
    .rk_wr (rk_wr)
  );

  aes256cbc_ram #(.Width(BLOCK_W), .Depth(NUM_RK)) u_rk_ram (
    .clk  (clk),
    .we   (rk_wr.we),
    .waddr(rk_wr.addr),
    .wdata(rk_wr.data),
    .raddr(rk_raddr),
    .rdata(rk)
  );

  aes256cbc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .status  (status),
    .rk_raddr(rk_raddr),
    .rk      (rk),
    .out_ch  (out_ch)
  );
endmodule

// ----- rtl/aes256cbc_ram.sv -----
module aes256cbc_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/aes256cbc_keyexp.sv -----
module aes256cbc_keyexp (
  input  logic                       clk,
  input  logic                       rst_n,
  aes256cbc_cfg_if.sink              cfg_ch,
  output aes256cbc_pkg::key_status_t status,
  output aes256cbc_pkg::rk_write_t   rk_wr
);
  import aes256cbc_pkg::*;

  logic [WORD_W-1:0] key_r [4];
  logic              decrypt_r;
  logic              busy_r;
  logic [EXP_CW-1:0] cnt_r;
  gf_byte_t          rc_r;
  kword_t            win_r [8];

  logic     cfg_fire;
  logic     restart;
  cfg_reg_t reg_sel;
  kword_t   key_word;
  kword_t   t;
  kword_t   new_w;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;
  assign reg_sel      = cfg_reg_t'(cfg_ch.index);

  always_comb begin
    restart = 1'b0;
    if (cfg_fire) begin
      case (reg_sel)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    key_word = cnt_r[0] ? key_r[cnt_r[2:1]][31:0] : key_r[cnt_r[2:1]][63:32];
    t = win_r[7];
    if (cnt_r[2:0] == 3'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rc_r, 24'h0};
    end else if (cnt_r[2:0] == 3'd4) begin
      t = sub_word(t);
    end
    new_w = (cnt_r < EXP_CW'(8)) ? key_word : (win_r[0] ^ t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]  <= '0;
      key_r[1]  <= '0;
      key_r[2]  <= '0;
      key_r[3]  <= '0;
      decrypt_r <= 1'b0;
    end else if (cfg_fire) begin
      case (reg_sel)
        REG_KEY0: key_r[0] <= cfg_ch.data;
        REG_KEY1: key_r[1] <= cfg_ch.data;
        REG_KEY2: key_r[2] <= cfg_ch.data;
        REG_KEY3: key_r[3] <= cfg_ch.data;
        REG_MODE: decrypt_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rc_r   <= 8'h01;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == EXP_CW'(EXP_WORDS - 1)) begin
        busy_r <= 1'b0;
      end
      if (cnt_r >= EXP_CW'(8) && cnt_r[2:0] == 3'd0) begin
        rc_r <= xtime(rc_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !restart) begin
      for (int j = 0; j < 7; j++) begin
        win_r[j] <= win_r[j+1];
      end
      win_r[7] <= new_w;
    end
  end

  assign rk_wr.we   = busy_r && !restart && (cnt_r[1:0] == 2'd3);
  assign rk_wr.addr = cnt_r[EXP_CW-1:2];
  assign rk_wr.data = {win_r[5], win_r[6], win_r[7], new_w};

  assign status.busy    = busy_r;
  assign status.decrypt = decrypt_r;
endmodule

// ----- rtl/aes256cbc_front.sv -----
module aes256cbc_front #(
  parameter int QDepth = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  aes256cbc_in_if.sink            in_ch,
  output logic                    q_valid,
  output aes256cbc_pkg::q_entry_t q_head,
  input  logic                    q_pop
);
  import aes256cbc_pkg::*;

  localparam int PW = $clog2(QDepth);
  localparam int CW = $clog2(QDepth + 1);

  q_entry_t        slot_r [QDepth];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            push;
  logic            pop;

  assign in_ch.ready = (count_r != CW'(QDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{data: {in_ch.data_high, in_ch.data_low},
                             first_block: in_ch.first_block};
    end
  end
endmodule

// ----- rtl/aes256cbc_core.sv -----
module aes256cbc_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  aes256cbc_pkg::q_entry_t       q_head,
  output logic                          q_pop,
  input  aes256cbc_pkg::key_status_t    status,
  output logic [aes256cbc_pkg::RK_AW-1:0] rk_raddr,
  input  aes256cbc_pkg::block_t         rk,
  aes256cbc_out_if.source               out_ch
);
  import aes256cbc_pkg::*;

  localparam logic [RK_AW-1:0] LAST = RK_AW'(NUM_ROUNDS);

  core_state_t      state_r, state_nxt;
  logic [RK_AW-1:0] rnd_r;
  logic             dec_r;
  block_t           s_r, cv_r, din_r, chain_r, out_data_r;
  logic             out_valid_r;

  logic   out_free;
  logic   done;
  block_t enc_t, dec_t, round_out;

  function automatic logic [RK_AW-1:0] key_idx(input logic dec, input logic [RK_AW-1:0] r);
    return dec ? (LAST - r) : r;
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;
  assign done     = (state_r == CS_ROUND) && (rnd_r == LAST) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE:  if (q_valid && !status.busy) state_nxt = CS_KEY0;
      CS_KEY0:  state_nxt = CS_ROUND;
      CS_ROUND: if (done) state_nxt = CS_IDLE;
      default:  state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    rk_raddr = '0;
    case (state_r)
      CS_IDLE: begin
        q_pop    = q_valid && !status.busy;
        rk_raddr = status.decrypt ? LAST : '0;
      end
      CS_KEY0:  rk_raddr = key_idx(dec_r, RK_AW'(1));
      CS_ROUND: rk_raddr = (rnd_r == LAST) ? key_idx(dec_r, rnd_r)
                                           : key_idx(dec_r, rnd_r + 1'b1);
      default: ;
    endcase
  end

  // one round per cycle, the last one waiting while the result register is full; the last round skips the column mix
  always_comb begin
    enc_t = shift_block(sub_block(s_r, 1'b0), 1'b0);
    if (rnd_r != LAST) enc_t = mix_block(enc_t, 1'b0);
    enc_t = enc_t ^ rk;
    dec_t = sub_block(shift_block(s_r, 1'b1), 1'b1) ^ rk;
    if (rnd_r != LAST) dec_t = mix_block(dec_t, 1'b1);
    round_out = dec_r ? dec_t : enc_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
      chain_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
        chain_r     <= dec_r ? din_r : round_out;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      din_r <= q_head.data;
      cv_r  <= q_head.first_block ? '0 : chain_r;
      dec_r <= status.decrypt;
      rnd_r <= RK_AW'(1);
    end
    if (state_r == CS_KEY0) begin
      s_r <= dec_r ? (din_r ^ rk) : (din_r ^ cv_r ^ rk);
    end
    if (state_r == CS_ROUND && rnd_r != LAST) begin
      s_r   <= round_out;
      rnd_r <= rnd_r + 1'b1;
    end
    if (done) begin
      out_data_r <= dec_r ? (round_out ^ cv_r) : round_out;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_high = out_data_r[127:64];
  assign out_ch.result_low  = out_data_r[63:0];

  a_key0_to_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == CS_KEY0 |=> state_r == CS_ROUND && rnd_r == RK_AW'(1))
    else $error("round phase did not follow initial key add");

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == CS_ROUND |-> rnd_r >= RK_AW'(1) && rnd_r <= LAST)
    else $error("round counter out of range");

  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == CS_ROUND && rnd_r == LAST))
    else $error("result raised outside last round");
endmodule

// ----- verif/aes256_cbc_cipher_top_tb.sv -----
`timescale 1ns / 100ps

module aes256_cbc_cipher_top_tb;
  import aes256cbc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 90;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef logic [7:0] aes_bytes_t [16];

  typedef struct {
    logic        mode;
    logic        load_key;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        first_block;
    logic        typed;
    logic [63:0] exp_high;
    logic [63:0] exp_low;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  aes256cbc_in_if  in_ch();
  aes256cbc_out_if out_ch();
  aes256cbc_cfg_if cfg_ch();

  aes256_cbc_cipher_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [7:0]   fwd_sub [256];
  logic [7:0]   inv_sub [256];
  logic [63:0]  key_reg [4];
  logic         dec_mode;
  logic [127:0] chain_blk;
  logic [127:0] sched_keys [15];

  logic [127:0] expected_blocks [$];
  int           mismatches = 0;
  int           cycles = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           recv_hold = 0;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) r = r ^ a;
      b = b >> 1;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] v, int s);
    return (v << s) | (v >> (8 - s));
  endfunction

  task automatic build_sub_tables();
    logic [7:0] a, iv, s;
    for (int i = 0; i < 256; i++) begin
      a = i[7:0];
      iv = a;
      for (int k = 0; k < 6; k++) iv = gf_mul(gf_mul(iv, iv), a);
      iv = gf_mul(iv, iv);
      s = 8'h63 ^ iv ^ rol8(iv, 1) ^ rol8(iv, 2) ^ rol8(iv, 3) ^ rol8(iv, 4);
      fwd_sub[i] = s;
      inv_sub[s] = a;
    end
  endtask

  task automatic expand_round_keys();
    logic [7:0] w [240];
    logic [7:0] t [4];
    logic [7:0] rc, x;
    rc = 8'h01;
    for (int n = 0; n < 32; n++) w[n] = key_reg[n / 8][63 - 8 * (n % 8) -: 8];
    for (int n = 32; n < 240; n += 4) begin
      for (int i = 0; i < 4; i++) t[i] = w[n - 4 + i];
      if (n % 32 == 0) begin
        x = t[0];
        t[0] = fwd_sub[t[1]] ^ rc;
        t[1] = fwd_sub[t[2]];
        t[2] = fwd_sub[t[3]];
        t[3] = fwd_sub[x];
        rc = gf_mul(rc, 8'h02);
      end else if (n % 32 == 16) begin
        for (int i = 0; i < 4; i++) t[i] = fwd_sub[t[i]];
      end
      for (int i = 0; i < 4; i++) w[n + i] = w[n - 32 + i] ^ t[i];
    end
    for (int r = 0; r < 15; r++)
      for (int i = 0; i < 16; i++) sched_keys[r][127 - 8 * i -: 8] = w[16 * r + i];
  endtask

  function automatic aes_bytes_t to_bytes(logic [127:0] v);
    aes_bytes_t b;
    for (int i = 0; i < 16; i++) b[i] = v[127 - 8 * i -: 8];
    return b;
  endfunction

  function automatic logic [127:0] from_bytes(aes_bytes_t b);
    logic [127:0] v;
    for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = b[i];
    return v;
  endfunction

  function automatic aes_bytes_t round_xform(aes_bytes_t s, logic inv, logic do_mix);
    aes_bytes_t t, o;
    logic [7:0] fm [4] = '{8'd2, 8'd3, 8'd1, 8'd1};
    logic [7:0] im [4] = '{8'd14, 8'd11, 8'd13, 8'd9};
    logic [7:0] acc;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (inv) t[r + 4 * ((c + r) % 4)] = inv_sub[s[r + 4 * c]];
        else     t[r + 4 * c] = fwd_sub[s[r + 4 * ((c + r) % 4)]];
      end
    if (!do_mix) return t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++)
          acc ^= gf_mul(t[4 * c + k], inv ? im[(k + 4 - r) % 4] : fm[(k + 4 - r) % 4]);
        o[4 * c + r] = acc;
      end
    return o;
  endfunction

  function automatic logic [127:0] aes_encrypt(logic [127:0] pt);
    logic [127:0] v;
    v = pt ^ sched_keys[0];
    for (int r = 1; r < 14; r++)
      v = from_bytes(round_xform(to_bytes(v), 1'b0, 1'b1)) ^ sched_keys[r];
    return from_bytes(round_xform(to_bytes(v), 1'b0, 1'b0)) ^ sched_keys[14];
  endfunction

  // pre-apply forward shift+sub so the inverse round below leaves only the mix
  function automatic aes_bytes_t round_xform_undo_sub(aes_bytes_t s);
    return round_xform(s, 1'b0, 1'b0);
  endfunction

  // inverse mix is linear, so apply it after the key add the way the cipher does
  function automatic logic [127:0] aes_decrypt(logic [127:0] ct);
    logic [127:0] v;
    aes_bytes_t b;
    v = ct ^ sched_keys[14];
    for (int r = 13; r > 0; r--) begin
      v = from_bytes(round_xform(to_bytes(v), 1'b1, 1'b0)) ^ sched_keys[r];
      b = to_bytes(v);
      v = from_bytes(round_xform(round_xform_undo_sub(b), 1'b1, 1'b1));
    end
    return from_bytes(round_xform(to_bytes(v), 1'b1, 1'b0)) ^ sched_keys[0];
  endfunction

  function automatic logic [127:0] cbc_step(logic [63:0] hi, logic [63:0] lo, logic first);
    logic [127:0] res;
    if (first) chain_blk = '0;
    if (!dec_mode) begin
      res = aes_encrypt({hi, lo} ^ chain_blk);
      chain_blk = res;
    end else begin
      res = aes_decrypt({hi, lo}) ^ chain_blk;
      chain_blk = {hi, lo};
    end
    return res;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
        key_reg[idx] = value;
        expand_round_keys();
      end
      REG_MODE: dec_mode = value[0];
      default: ;
    endcase
    // let the drop of valid take effect before the next beat
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_blocks.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic first,
                            logic typed, logic [127:0] typed_exp);
    logic [127:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_high   <= hi;
    in_ch.data_low    <= lo;
    in_ch.first_block <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = cbc_step(hi, lo, first);
    expected_blocks.push_back(typed ? typed_exp : pred);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // receiver ready, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      out_ch.ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [127:0] exp_blk;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected result beat %h %h", out_ch.result_high, out_ch.result_low);
        mismatches++;
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (out_ch.result_high !== exp_blk[127:64]) begin
          $error("result_high expected %h actual %h", exp_blk[127:64], out_ch.result_high);
          mismatches++;
        end
        if (out_ch.result_low !== exp_blk[63:0]) begin
          $error("result_low expected %h actual %h", exp_blk[63:0], out_ch.result_low);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  localparam logic [63:0] STD_KEY [4] = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                                          64'h1011121314151617, 64'h18191a1b1c1d1e1f};

  vec_row_t vec_rows [9] = '{
    '{1'b0, 1'b0, 64'h0, 64'h0, 1'b1, 1'b1, 64'hdc95c078a2408989, 64'had48a21492842087},
    '{1'b0, 1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b1,
      64'h8ea2b7ca516745bf, 64'heafc49904b496089},
    '{1'b0, 1'b0, '1, '1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{1'b1, 1'b0, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1, 1'b1,
      64'h0011223344556677, 64'h8899aabbccddeeff},
    '{1'b1, 1'b0, 64'h5a5a5a5a0f0f0f0f, 64'h8000000000000001, 1'b0, 1'b0, 64'h0, 64'h0},
    '{1'b1, 1'b0, '1, '1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{1'b0, 1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b0, 64'h0, 64'h0},
    '{1'b1, 1'b0, 64'h0, 64'h0, 1'b1, 1'b0, 64'h0, 64'h0}
  };

  initial begin
    int msg_left;
    logic first;
    in_ch.valid = 1'b0;
    in_ch.data_high = '0;
    in_ch.data_low = '0;
    in_ch.first_block = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_KEY0;
    cfg_ch.data = '0;
    build_sub_tables();
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    dec_mode = 1'b0;
    chain_blk = '0;
    expand_round_keys();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 17;
    recv_idle_pct = 73;
    foreach (vec_rows[r]) begin
      if (vec_rows[r].load_key || vec_rows[r].mode != dec_mode) begin
        drain();
        if (vec_rows[r].load_key)
          for (int k = 0; k < 4; k++) cfg_write(cfg_reg_t'(k), STD_KEY[k]);
        if (vec_rows[r].mode != dec_mode) cfg_write(REG_MODE, {63'h0, vec_rows[r].mode});
      end
      send_block(vec_rows[r].data_high, vec_rows[r].data_low, vec_rows[r].first_block,
                 vec_rows[r].typed, {vec_rows[r].exp_high, vec_rows[r].exp_low});
    end

    msg_left = 0;
    for (int ph = 0; ph < 18; ph++) begin
      send_idle_pct = (ph < 6) ? 17 : (ph < 12) ? 73 : 0;
      recv_idle_pct = (ph < 6) ? 73 : (ph < 12) ? 17 : 0;
      drain();
      for (int k = 0; k < 4; k++) begin
        if (ph == 1)      cfg_write(cfg_reg_t'(k), '1);
        else if (ph == 2) cfg_write(cfg_reg_t'(k), '0);
        else if (ph == 0 || $urandom_range(1)) cfg_write(cfg_reg_t'(k), rand_word());
      end
      if (ph == 3) cfg_write(REG_UNUSED, '1);
      cfg_write(REG_MODE, {$urandom, $urandom});
      if (ph == 7) recv_hold = 400;
      for (int n = 0; n < 90; n++) begin
        // hold input until the pipeline is empty once mid-phase
        if (ph == 8 && n == 45) begin
          in_ch.valid <= 1'b0;
          while (expected_blocks.size() > 0) @(posedge clk);
        end
        if (msg_left == 0) begin
          msg_left = $urandom_range(8, 1);
          first = ($urandom_range(19) != 0);
        end else begin
          first = ($urandom_range(19) == 0);
        end
        msg_left--;
        send_block(rand_word(), rand_word(), first, 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
